// File: rtl/core/assert_macros.svh
// assertion macros of the port-level checker
// every macro samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge outside reset
`define SLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked at each rising clock edge outside reset
`define SLE_ASSERT_IMP(lbl, pre, post, msg) \
	`SLE_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// File: rtl/core/slist_pkg.sv
// shared types and constants of the sorted list engine
// no dependencies
`timescale 1ns / 1ps

package slist_pkg;

	localparam int CMD_W   = 2;
	localparam int VAL_W   = 8;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic execute;
	} ctl_cmd_t;

endpackage

// File: rtl/core/slist_ctrl.sv
// controller of the sorted list engine: item handshake and sequencing
// depends on slist_pkg
`timescale 1ns / 1ps

module slist_ctrl import slist_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign ctl.capture = in_valid && in_ready;
	assign ctl.compare = (state_q == ST_CMP);
	// finish only once the output register is free
	assign ctl.execute = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.capture) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ctl.execute) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctl.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/slist_datapath.sv
// datapath of the sorted list engine: compare-and-shift cells, count, result register
// depends on slist_pkg
`timescale 1ns / 1ps

module slist_datapath import slist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_cmd_t                ctl,
	input  logic [CMD_W-1:0]        in_cmd,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic [POS_W-1:0]        in_pos,
	output logic                    out_ok,
	output logic signed [VAL_W-1:0] out_read_value,
	output logic [COUNT_W-1:0]      out_entry_count
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int GRP = 32;
	localparam int NG  = (CAPACITY + GRP - 1) / GRP;
	localparam int PW  = (CW > POS_W) ? CW : POS_W;
	localparam int OW  = (CW > COUNT_W) ? CW : COUNT_W;

	logic signed [VAL_W-1:0] cell_q [CAPACITY];
	logic [CW-1:0]           count_q;
	logic [CMD_W-1:0]        cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;

	logic [CAPACITY-1:0]     lt_s1;
	logic [VAL_W-1:0]        rd_grp_s1 [NG];
	logic [NG-1:0]           eq_grp_s1;

	logic                    ok_q;
	logic signed [VAL_W-1:0] rd_q;

	logic [CAPACITY-1:0]     lt_c;
	logic [CAPACITY-1:0]     prev_lt_c;
	logic [CAPACITY-1:0]     eq_c;
	logic [VAL_W-1:0]        rd_grp_d [NG];
	logic [NG-1:0]           eq_grp_d;
	logic [CAPACITY-1:0]     prev_lt_s1;
	logic signed [VAL_W-1:0] up_c [CAPACITY];
	logic signed [VAL_W-1:0] down_c [CAPACITY];
	logic                    found_c;
	logic [VAL_W-1:0]        rd_val_c;
	logic                    ins_ok_c;
	logic                    rd_ok_c;
	logic                    ok_c;

	// per-cell compare against the item value, and the read select
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_c[i] = (CW'(i) < count_q) && (cell_q[i] < val_q);
		end
		prev_lt_c = {lt_c[CAPACITY-2:0], 1'b1};
		for (int i = 0; i < CAPACITY; i++) begin
			eq_c[i] = (CW'(i) < count_q) && !lt_c[i] && prev_lt_c[i]
				&& (cell_q[i] == val_q);
		end
		for (int g = 0; g < NG; g++) begin
			rd_grp_d[g] = '0;
		end
		eq_grp_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (32'(pos_q) == i) rd_grp_d[i / GRP] = rd_grp_d[i / GRP] | cell_q[i];
			eq_grp_d[i / GRP] = eq_grp_d[i / GRP] | eq_c[i];
		end
	end

	// neighbor values for the shift, and the result of the operation
	always_comb begin
		up_c[0] = val_q;
		for (int i = 1; i < CAPACITY; i++) begin
			up_c[i] = cell_q[i-1];
		end
		for (int i = 0; i < CAPACITY - 1; i++) begin
			down_c[i] = cell_q[i+1];
		end
		down_c[CAPACITY-1] = cell_q[CAPACITY-1];
		prev_lt_s1 = {lt_s1[CAPACITY-2:0], 1'b1};
		found_c    = |eq_grp_s1;
		rd_val_c   = '0;
		for (int g = 0; g < NG; g++) begin
			rd_val_c = rd_val_c | rd_grp_s1[g];
		end
		ins_ok_c = (count_q < CW'(CAPACITY));
		rd_ok_c  = (PW'(pos_q) < PW'(count_q));
		case (cmd_q)
			CMD_INSERT: ok_c = ins_ok_c;
			CMD_REMOVE: ok_c = found_c;
			CMD_READ:   ok_c = rd_ok_c;
			default:    ok_c = (count_q != '0);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.execute && ok_c) begin
			case (cmd_q)
				CMD_INSERT: count_q <= count_q + CW'(1);
				CMD_REMOVE: count_q <= count_q - CW'(1);
				CMD_CLEAR:  count_q <= '0;
				default:    count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= in_cmd;
			val_q <= in_value;
			pos_q <= in_pos;
		end
		if (ctl.compare) begin
			lt_s1     <= lt_c;
			rd_grp_s1 <= rd_grp_d;
			eq_grp_s1 <= eq_grp_d;
		end
		if (ctl.execute) begin
			ok_q <= ok_c;
			rd_q <= (cmd_q == CMD_READ && rd_ok_c) ? rd_val_c : '0;
			if (cmd_q == CMD_INSERT && ins_ok_c) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (!lt_s1[i]) cell_q[i] <= prev_lt_s1[i] ? val_q : up_c[i];
				end
			end
			if (cmd_q == CMD_REMOVE && found_c) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (!lt_s1[i]) cell_q[i] <= down_c[i];
				end
			end
		end
	end

	// count register follows the store, so the output shows it after the update
	logic [CW-1:0] cnt_shown_q;

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			case (cmd_q)
				CMD_INSERT: cnt_shown_q <= ins_ok_c ? count_q + CW'(1) : count_q;
				CMD_REMOVE: cnt_shown_q <= found_c ? count_q - CW'(1) : count_q;
				CMD_CLEAR:  cnt_shown_q <= '0;
				default:    cnt_shown_q <= count_q;
			endcase
		end
	end

	assign out_ok          = ok_q;
	assign out_read_value  = rd_q;
	assign out_entry_count = COUNT_W'(OW'(cnt_shown_q));

endmodule

// File: rtl/core/sorted_list_engine.sv
// top level of the sorted list engine: stream ports, controller and datapath
// depends on slist_pkg, slist_ctrl, slist_datapath
`timescale 1ns / 1ps

// Sorted list engine. Keeps up to CAPACITY signed bytes in ascending order in
// a row of compare-and-shift cells. The command rides on s_axis_tuser: insert,
// remove one occurrence, read at a position, clear. Every item gives one result
// with a success flag, the value read (zero unless a read succeeds) and the
// count after the operation, modulo 128. An item is first captured; then
// every cell compares against the value and the read select is reduced per
// group of 32 cells; last the groups are combined and the cells shift. A new
// item is taken as soon as the previous one has been written to the output
// register, even while that result is still waiting; the block holds in its
// last step only when that register is still full.
module sorted_list_engine import slist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // item_value [7:0], position [15:8]
	input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // read_value [7:0], entry_count [14:8], zero [15]
	output logic        m_axis_tuser    // ok [0]
);

	ctl_cmd_t                ctl;
	logic                    ok;
	logic signed [VAL_W-1:0] read_value;
	logic [COUNT_W-1:0]      entry_count;

	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	slist_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.in_cmd          (s_axis_tuser),
		.in_value        (s_axis_tdata[7:0]),
		.in_pos          (s_axis_tdata[15:8]),
		.out_ok          (ok),
		.out_read_value  (read_value),
		.out_entry_count (entry_count)
	);

	assign m_axis_tdata = {1'b0, entry_count, read_value};
	assign m_axis_tuser = ok;

endmodule

// File: rtl/core/slist_checker.sv
// port-level checks of the sorted list engine, bound to the top level
// depends on assert_macros.svh and sorted_list_engine
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slist_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic        in_take;
	logic        out_stall;
	logic        out_fail;
	logic [16:0] m_out;
	logic        count_high;

	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign out_fail   = m_axis_tvalid && !m_axis_tuser;
	assign m_out      = {m_axis_tuser, m_axis_tdata};
	assign count_high = (CAPACITY < 128) && (32'(m_axis_tdata[14:8]) > CAPACITY);

	// a held result does not change
	`SLE_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_out), "held result changed")

	// one item at a time: no item is taken in the cycle after one was taken
	`SLE_ASSERT(a_one_at_a_time, in_take |=> !s_axis_tready, "item taken while busy")

	// a failed operation never shows a read value
	`SLE_ASSERT_IMP(a_fail_zero, out_fail, m_axis_tdata[7:0] == 8'd0, "value on failed item")

	// the count never exceeds the capacity
	`SLE_ASSERT_IMP(a_count_bound, m_axis_tvalid, !count_high, "count above capacity")

endmodule

bind sorted_list_engine slist_checker #(.CAPACITY(CAPACITY)) u_slist_checker (.*);

// File: test/sorted_list_checker.sv
// result checker for the sorted list engine: tracks the stored values itself
// and compares every result item against its own prediction; uses slist_pkg
`timescale 1ns / 1ps

module sorted_list_checker import slist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // item_value [7:0], position [15:8]
	input  logic [1:0]  s_tuser,    // cmd [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,    // read_value [7:0], entry_count [14:8]
	input  logic        m_tuser,    // ok [0]
	output int          outstanding,
	output int          errors
);

	typedef struct packed {
		logic              ok;
		logic signed [7:0] read_value;
		logic [6:0]        entry_count;
	} list_reply_t;

	logic signed [7:0] list_vals [CAPACITY];
	int unsigned       list_len;
	list_reply_t       replies_due [$];
	int                error_tally;

	// applies one command to the tracked list and returns what the block must answer
	task automatic apply_command(input logic [1:0] op, input logic signed [7:0] v,
			input logic [7:0] pos, output list_reply_t reply);
		int unsigned idx;
		int unsigned k;
		reply = '0;
		case (op)
			CMD_INSERT: begin
				if (list_len < CAPACITY) begin
					idx = 0;
					while (idx < list_len && list_vals[idx] < v)
						idx++;
					for (k = list_len; k > idx; k--)
						list_vals[k] = list_vals[k-1];
					list_vals[idx] = v;
					list_len++;
					reply.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				idx = 0;
				while (idx < list_len && list_vals[idx] < v)
					idx++;
				if (idx < list_len && list_vals[idx] == v) begin
					for (k = idx; k + 1 < list_len; k++)
						list_vals[k] = list_vals[k+1];
					list_len--;
					reply.ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (pos < list_len) begin
					reply.read_value = list_vals[pos];
					reply.ok = 1'b1;
				end
			end
			default: begin
				if (list_len > 0) begin
					list_len = 0;
					reply.ok = 1'b1;
				end
			end
		endcase
		reply.entry_count = list_len[6:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		list_reply_t got;
		if (!arst_n) begin
			list_len = 0;
			replies_due.delete();
			outstanding <= 0;
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got.ok = m_tuser;
				got.read_value = m_tdata[7:0];
				got.entry_count = m_tdata[14:8];
				if (replies_due.size() == 0) begin
					$display("%0t: result item with nothing expected: ok %0b value %0d count %0d",
						$time, got.ok, got.read_value, got.entry_count);
					error_tally++;
				end else begin
					want = replies_due.pop_front();
					if (got.ok !== want.ok) begin
						$display("%0t: ok expected %0b got %0b", $time, want.ok, got.ok);
						error_tally++;
					end
					if (got.read_value !== want.read_value) begin
						$display("%0t: read_value expected %0d got %0d", $time,
							want.read_value, got.read_value);
						error_tally++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d got %0d", $time,
							want.entry_count, got.entry_count);
						error_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_command(s_tuser, s_tdata[7:0], s_tdata[15:8], want);
				replies_due.push_back(want);
			end
			outstanding <= replies_due.size();
			errors <= error_tally;
		end
	end

endmodule

// File: test/tb_sorted_list_engine.sv
// testbench top for the sorted list engine: clock, reset, stimulus and verdict
// depends on slist_pkg, sorted_list_engine and sorted_list_checker
`timescale 1ns / 1ps

module tb_sorted_list_engine;
	import slist_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int RAND_ITEMS = 700;
	localparam int LIMIT      = 600000;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} phase_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = CMD_READ;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	int outstanding;
	int errors;
	int cycle_count = 0;
	bit steady = 1'b0;

	always #1 clk = ~clk;

	sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	sorted_list_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tuser(m_axis_tuser),
		.outstanding(outstanding),
		.errors(errors)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// values from a narrow pool so removes find their match, sometimes any byte
	function automatic logic [7:0] pick_value(input int narrow_pct);
		if ($urandom_range(0, 99) < narrow_pct)
			return 8'($urandom_range(0, 11) - 6);
		return 8'($urandom);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [7:0] val, input logic [7:0] pos);
		int gap;
		gap = steady ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pos, val};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// result side: random ready with stalls, held high in steady phases
	initial begin
		int hold;
		hold = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (steady) begin
				m_axis_tready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 99) < 65) begin
				m_axis_tready <= 1'b1;
				hold = $urandom_range(0, 15);
			end else begin
				m_axis_tready <= 1'b0;
				hold = gap_len();
			end
		end
	end

	initial begin
		phase_mode_t mode;
		int sent;
		int phase_len;
		int phase_no;
		int r;
		logic [1:0] op;
		logic [7:0] pos;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-store failures, extremes, duplicates, range edges
		send_item(CMD_CLEAR,  8'd0,    8'd0);
		send_item(CMD_READ,   8'd0,    8'd0);
		send_item(CMD_REMOVE, 8'd5,    8'd0);
		send_item(CMD_INSERT, 8'h7f,   8'd0);
		send_item(CMD_INSERT, 8'h80,   8'd0);
		send_item(CMD_INSERT, 8'd0,    8'd0);
		send_item(CMD_INSERT, 8'd0,    8'd0);
		send_item(CMD_INSERT, 8'hff,   8'd0);
		send_item(CMD_READ,   8'd0,    8'd0);
		send_item(CMD_READ,   8'd0,    8'd4);
		send_item(CMD_READ,   8'd0,    8'd5);
		send_item(CMD_READ,   8'hff,   8'd255);
		send_item(CMD_REMOVE, 8'd0,    8'd0);
		send_item(CMD_READ,   8'd0,    8'd2);
		send_item(CMD_REMOVE, 8'd5,    8'd0);
		send_item(CMD_REMOVE, 8'h80,   8'd0);
		send_item(CMD_REMOVE, 8'h7f,   8'd0);
		send_item(CMD_READ,   8'd0,    8'd1);
		send_item(CMD_CLEAR,  8'd0,    8'd0);
		send_item(CMD_CLEAR,  8'd0,    8'd0);
		wait_drained();

		sent = 0;
		phase_no = 0;
		while (sent < RAND_ITEMS) begin
			// the first phase fills the store far enough to hit the full case
			if (phase_no == 0) begin
				mode = MODE_FILL;
				phase_len = 100;
			end else begin
				mode = phase_mode_t'($urandom_range(0, 2));
				phase_len = $urandom_range(30, 110);
			end
			steady = (phase_no % 4 == 3);
			if (phase_len > RAND_ITEMS - sent)
				phase_len = RAND_ITEMS - sent;
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				pos = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 70));
				case (mode)
					MODE_FILL:  op = (r < 80) ? CMD_INSERT : (r < 88) ? CMD_REMOVE : CMD_READ;
					MODE_DRAIN: op = (r < 15) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : CMD_READ;
					default:    op = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
						(r < 95) ? CMD_READ : CMD_CLEAR;
				endcase
				send_item(op, pick_value(mode == MODE_MIX ? 50 : 75), pos);
				sent++;
			end
			if (phase_no == 0 || $urandom_range(0, 2) == 0)
				wait_drained();
			phase_no++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
